// ----- hw/rtl/i2r_pkg.sv -----
// shared types, constants and helpers for the 128-bit integer to radix text block
package i2r_pkg;

    // magnitude word and the shared divider's step plan
    localparam int WORD_W    = 128;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = WORD_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // digit store and text length
    localparam int DIGIT_MAX = 128;
    localparam int ADDR_W    = $clog2(DIGIT_MAX);
    localparam int LEN_W     = ADDR_W + 1;

    // radix range
    localparam int RADIX_W = 6;
    localparam logic [RADIX_W-1:0] MIN_RADIX     = 6'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX     = 6'd36;
    localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 6'd10;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_WR   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // digit value to its ascii character
    function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] dgt);
        logic [7:0] wide;
        wide = {2'b00, dgt};
        if (dgt < 6'd10) begin
            digit_char = CHAR_ZERO + wide;
        end else begin
            digit_char = CHAR_A + (wide - 8'd10);
        end
    endfunction

endpackage

// ----- hw/rtl/i2r_div.sv -----
// iterative 128-bit by small radix divider, eight quotient bits per cycle
module i2r_div import i2r_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_W-1:0]    i_dividend,
    input  logic [RADIX_W-1:0]   i_divisor,
    output logic                 o_done,
    output logic [WORD_W-1:0]    o_quotient,
    output logic [RADIX_W-1:0]   o_remainder
);

    logic [WORD_W-1:0]   r_work;
    logic [RADIX_W-1:0]  r_rem;
    logic [RADIX_W-1:0]  r_divisor;
    logic [STEP_W-1:0]   r_step;
    logic                r_busy;
    logic                r_done;

    logic [RADIX_W-1:0]  n_rem;
    logic [DIV_BITS-1:0] n_qbyte;
    logic [RADIX_W:0]    trial;

    // restoring division over the top byte of the working word
    always_comb begin
        n_rem   = r_rem;
        n_qbyte = '0;
        trial   = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {n_rem, r_work[WORD_W-1-i]};
            if (trial >= {1'b0, r_divisor}) begin
                trial = trial - {1'b0, r_divisor};
                n_qbyte[DIV_BITS-1-i] = 1'b1;
            end
            n_rem = trial[RADIX_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out on top, quotient shifts in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[WORD_W-DIV_BITS-1:0], n_qbyte};
            r_rem  <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule

// ----- hw/rtl/int128_to_radix_text.sv -----
// top level: signed 128-bit integer to packed ascii text in radix 2..36
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_value_high, i_value_low, i_radix
//  out      source     o_out_valid / i_out_ready  o_text_chars, o_char_count, o_last
//
// each digit passes through the shared divider: start, 16 steps of 8 bits, done
// each character then passes the digit memory read port (S_RD, then S_WR), and each
// result beat adds an S_OUT state; radix 2 of a 128-bit magnitude is the worst case
// one transaction is in flight at a time; o_in_ready is high only when idle
// a stalled result holds the sequencer; reset is synchronous and needs no clearing pass
module int128_to_radix_text import i2r_pkg::*; #(
    parameter int CHARS_PER_RESULT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [63:0] i_value_high,
    input  logic [63:0]        i_value_low,
    input  logic [5:0]         i_radix,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [63:0]        o_text_chars,
    output logic [3:0]         o_char_count,
    output logic               o_last
);

    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHARS_PER_RESULT - 1);

    t_state               r_state;
    logic [WORD_W-1:0]    r_mag;
    logic [RADIX_W-1:0]   r_radix;
    logic                 r_neg;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W:0]       r_pos;
    logic [LEN_W:0]       r_total;
    logic [SLOT_W-1:0]    r_slot;
    logic [63:0]          r_beat;
    logic                 r_last;
    logic                 r_div_start;
    logic [7:0]           r_rd_data;
    logic [7:0]           r_text_mem [DIGIT_MAX];

    logic                 div_done;
    logic [WORD_W-1:0]    div_quot;
    logic [RADIX_W-1:0]   div_rem;
    logic [WORD_W-1:0]    in_word;
    logic [RADIX_W-1:0]   in_radix;
    logic [LEN_W:0]       rd_index;
    logic [ADDR_W-1:0]    rd_addr;
    logic [LEN_W-1:0]     len_next;
    logic [LEN_W:0]       pos_next;
    logic [7:0]           cur_char;

    // shared divider
    i2r_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_mag),
        .i_divisor   (r_radix),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // input conditioning
    assign in_word  = {i_value_high, i_value_low};
    assign in_radix = (i_radix < MIN_RADIX || i_radix > MAX_RADIX) ? DEFAULT_RADIX : i_radix;

    // digits are stored least significant first, read back most significant first
    assign rd_index = {1'b0, r_len} - (LEN_W+1)'(1) - r_pos + {{LEN_W{1'b0}}, r_neg};
    assign rd_addr  = rd_index[ADDR_W-1:0];
    assign len_next = r_len + 1'b1;
    assign pos_next = r_pos + 1'b1;
    assign cur_char = (r_neg && r_pos == '0) ? CHAR_MINUS : r_rd_data;

    // digit memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            r_text_mem[r_len[ADDR_W-1:0]] <= digit_char(div_rem);
        end
        r_rd_data <= r_text_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_last      <= 1'b0;
            r_slot      <= '0;
            r_pos       <= '0;
            r_len       <= '0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_neg       <= i_value_high[63];
                        r_mag       <= i_value_high[63] ? (~in_word + 128'd1) : in_word;
                        r_radix     <= in_radix;
                        r_len       <= '0;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_len <= len_next;
                        if (div_quot != '0 && len_next < LEN_W'(DIGIT_MAX)) begin
                            r_mag       <= div_quot;
                            r_div_start <= 1'b1;
                        end else begin
                            r_total <= {1'b0, len_next} + {{LEN_W{1'b0}}, r_neg};
                            r_pos   <= '0;
                            r_slot  <= '0;
                            r_beat  <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_beat[{r_slot, 3'b000} +: 8] <= cur_char;
                    r_pos <= pos_next;
                    if (r_slot == LAST_SLOT || pos_next == r_total) begin
                        r_last  <= (pos_next == r_total);
                        r_state <= S_OUT;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= '0;
                            r_beat  <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_text_chars = r_beat;
    assign o_char_count = {1'b0, r_slot} + 4'd1;
    assign o_last       = r_last;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_char_count != 4'd0 && o_char_count <= 4'(CHARS_PER_RESULT)))
        else $error("result character count out of range");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("block not ready after final result transaction");

    a_start_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIV))
        else $error("divider started outside the divide phase");

endmodule
